FILE: hw/rtl/dra_pkg.sv
// Shared types and constants for the DNS response address extractor.
// No dependencies; imported by the parser, the top level and the checker.
package dra_pkg;

   localparam int unsigned ID_WIDTH   = 16;
   localparam int unsigned ADDR_WIDTH = 32;

   typedef logic [1:0] status_type;

   localparam status_type ST_FOUND    = 2'd0;
   localparam status_type ST_MISMATCH = 2'd1;
   localparam status_type ST_TRUNC    = 2'd2;
   localparam status_type ST_NONE     = 2'd3;

   localparam logic [15:0] TYPE_A   = 16'd1;
   localparam logic [15:0] CLASS_IN = 16'd1;
   localparam logic [15:0] ADDR_LEN = 16'd4;
   localparam logic [1:0]  PTR_MARK = 2'b11;

   typedef struct packed {
      status_type            status;
      logic [ADDR_WIDTH-1:0] address;
   } result_type;

endpackage

FILE: hw/rtl/dns_response_address_extractor_top.sv
// A last-byte transaction passes the input register, then the result register, before its result transaction.
// Throughput: one byte per cycle when not stalled; input register, parser, result register.
// The parser consumes a byte each cycle unless a last byte meets a held result.
// Reset: synchronous, active high; clears parser state, the valid flags and expected id.
// Top level of the DNS response address extractor; depends on dra_pkg, dra_parser.
module dns_response_address_extractor_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_last_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output dra_pkg::status_type            rsp_status,
   output logic [dra_pkg::ADDR_WIDTH-1:0] rsp_ipv4_address,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dra_pkg::ID_WIDTH-1:0]   csr_expected_id
);
   import dra_pkg::*;

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_last_ff;
   logic                  rsp_valid_ff;
   result_type            rsp_ff;
   logic [ID_WIDTH-1:0]   expected_id_ff;
   logic                  out_free;
   logic                  take;
   result_type            result;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign take      = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || take;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= '0;
      end else if (csr_valid) begin
         expected_id_ff <= csr_expected_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   dra_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .data_byte   (in_byte_ff),
      .last_byte   (in_last_ff),
      .expected_id (expected_id_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_last_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_ipv4_address = rsp_ff.address;

endmodule

FILE: hw/rtl/dra_parser.sv
// Byte-wise DNS message parser: header, question skip, answer walk.
// Depends on dra_pkg. Gives the result for the byte taken in this cycle.
module dra_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           take,
   input  logic [7:0]                     data_byte,
   input  logic                           last_byte,
   input  logic [dra_pkg::ID_WIDTH-1:0]   expected_id,
   output dra_pkg::result_type            result
);
   import dra_pkg::*;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_NLEN   = 3'd1;
   localparam logic [2:0] PH_NLABEL = 3'd2;
   localparam logic [2:0] PH_NPTR   = 3'd3;
   localparam logic [2:0] PH_QFIXED = 3'd4;
   localparam logic [2:0] PH_AFIXED = 3'd5;
   localparam logic [2:0] PH_ADATA  = 3'd6;
   localparam logic [2:0] PH_DONE   = 3'd7;

   logic [2:0]            phase_ff,   phase_in;
   logic [3:0]            fcnt_ff,    fcnt_in;
   logic [15:0]           qleft_ff,   qleft_in;
   logic [15:0]           aleft_ff,   aleft_in;
   logic [7:0]            lbl_ff,     lbl_in;
   logic [15:0]           rtype_ff,   rtype_in;
   logic [15:0]           rclass_ff,  rclass_in;
   logic [15:0]           rdata_ff,   rdata_in;
   logic [15:0]           id_ff,      id_in;
   logic [31:0]           addr_ff,    addr_in;
   status_type            outcome_ff, outcome_in;

   logic [15:0] q_dec;
   logic [15:0] a_dec;
   logic [15:0] rdata_dec;
   logic [15:0] rdata_new;
   logic [7:0]  lbl_dec;

   assign q_dec     = qleft_ff - 16'd1;
   assign a_dec     = aleft_ff - 16'd1;
   assign rdata_dec = rdata_ff - 16'd1;
   assign rdata_new = {rdata_ff[15:8], data_byte};
   assign lbl_dec   = lbl_ff - 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      fcnt_in    = fcnt_ff;
      qleft_in   = qleft_ff;
      aleft_in   = aleft_ff;
      lbl_in     = lbl_ff;
      rtype_in   = rtype_ff;
      rclass_in  = rclass_ff;
      rdata_in   = rdata_ff;
      id_in      = id_ff;
      addr_in    = addr_ff;
      outcome_in = outcome_ff;
      case (phase_ff)
         PH_HEADER: begin
            case (fcnt_ff)
               4'd0:    id_in    = {data_byte, 8'h00};
               4'd1:    id_in    = {id_ff[15:8], data_byte};
               4'd4:    qleft_in = {data_byte, 8'h00};
               4'd5:    qleft_in = {qleft_ff[15:8], data_byte};
               4'd6:    aleft_in = {data_byte, 8'h00};
               4'd7:    aleft_in = {aleft_ff[15:8], data_byte};
               default: ;
            endcase
            if (fcnt_ff >= 4'd11) begin
               fcnt_in = 4'd0;
               if (id_ff != expected_id) begin
                  outcome_in = ST_MISMATCH;
                  phase_in   = PH_DONE;
               end else if (qleft_ff != 16'd0 || aleft_ff != 16'd0) begin
                  phase_in = PH_NLEN;
               end else begin
                  outcome_in = ST_NONE;
                  phase_in   = PH_DONE;
               end
            end else begin
               fcnt_in = fcnt_ff + 4'd1;
            end
         end
         PH_NLEN: begin
            if (data_byte[7:6] == PTR_MARK) begin
               phase_in = PH_NPTR;
            end else if (data_byte == 8'd0) begin
               fcnt_in  = 4'd0;
               phase_in = (qleft_ff != 16'd0) ? PH_QFIXED : PH_AFIXED;
            end else begin
               lbl_in   = data_byte;
               phase_in = PH_NLABEL;
            end
         end
         PH_NLABEL: begin
            lbl_in = lbl_dec;
            if (lbl_dec == 8'd0) begin
               phase_in = PH_NLEN;
            end
         end
         PH_NPTR: begin
            fcnt_in  = 4'd0;
            phase_in = (qleft_ff != 16'd0) ? PH_QFIXED : PH_AFIXED;
         end
         PH_QFIXED: begin
            if (fcnt_ff >= 4'd3) begin
               fcnt_in  = 4'd0;
               qleft_in = q_dec;
               if (q_dec != 16'd0 || aleft_ff != 16'd0) begin
                  phase_in = PH_NLEN;
               end else begin
                  outcome_in = ST_NONE;
                  phase_in   = PH_DONE;
               end
            end else begin
               fcnt_in = fcnt_ff + 4'd1;
            end
         end
         PH_AFIXED: begin
            case (fcnt_ff)
               4'd0:    rtype_in  = {data_byte, 8'h00};
               4'd1:    rtype_in  = {rtype_ff[15:8], data_byte};
               4'd2:    rclass_in = {data_byte, 8'h00};
               4'd3:    rclass_in = {rclass_ff[15:8], data_byte};
               4'd8:    rdata_in  = {data_byte, 8'h00};
               4'd9:    rdata_in  = rdata_new;
               default: ;
            endcase
            if (fcnt_ff >= 4'd9) begin
               fcnt_in = 4'd0;
               if (!(rtype_ff == TYPE_A && rclass_ff == CLASS_IN && rdata_new == ADDR_LEN)) begin
                  rtype_in = 16'd0;
               end
               addr_in = 32'd0;
               if (rdata_new == 16'd0) begin
                  aleft_in = a_dec;
                  if (qleft_ff != 16'd0 || a_dec != 16'd0) begin
                     phase_in = PH_NLEN;
                  end else begin
                     outcome_in = ST_NONE;
                     phase_in   = PH_DONE;
                  end
               end else begin
                  phase_in = PH_ADATA;
               end
            end else begin
               fcnt_in = fcnt_ff + 4'd1;
            end
         end
         PH_ADATA: begin
            if (rtype_ff == TYPE_A) begin
               addr_in = {addr_ff[23:0], data_byte};
            end
            rdata_in = rdata_dec;
            if (rdata_dec == 16'd0) begin
               if (rtype_ff == TYPE_A) begin
                  outcome_in = ST_FOUND;
                  phase_in   = PH_DONE;
               end else begin
                  aleft_in = a_dec;
                  if (qleft_ff != 16'd0 || a_dec != 16'd0) begin
                     phase_in = PH_NLEN;
                  end else begin
                     outcome_in = ST_NONE;
                     phase_in   = PH_DONE;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      result.status  = (phase_in == PH_DONE) ? outcome_in : ST_TRUNC;
      result.address = (result.status == ST_FOUND) ? addr_in : '0;
   end

   // last byte closes the message: back to header state
   always_ff @(posedge clock) begin
      if (reset || (take && last_byte)) begin
         phase_ff   <= PH_HEADER;
         fcnt_ff    <= '0;
         qleft_ff   <= '0;
         aleft_ff   <= '0;
         lbl_ff     <= '0;
         rtype_ff   <= '0;
         rclass_ff  <= '0;
         rdata_ff   <= '0;
         id_ff      <= '0;
         addr_ff    <= '0;
         outcome_ff <= ST_NONE;
      end else if (take) begin
         phase_ff   <= phase_in;
         fcnt_ff    <= fcnt_in;
         qleft_ff   <= qleft_in;
         aleft_ff   <= aleft_in;
         lbl_ff     <= lbl_in;
         rtype_ff   <= rtype_in;
         rclass_ff  <= rclass_in;
         rdata_ff   <= rdata_in;
         id_ff      <= id_in;
         addr_ff    <= addr_in;
         outcome_ff <= outcome_in;
      end
   end

endmodule

FILE: hw/rtl/dra_checker.sv
// Port-level checks for the DNS response address extractor, bound to the top.
// Depends on dra_pkg and dns_response_address_extractor_top.
module dra_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input dra_pkg::status_type            rsp_status,
   input logic [dra_pkg::ADDR_WIDTH-1:0] rsp_ipv4_address
);
   import dra_pkg::*;

   // held result transaction keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_ipv4_address))
      else $error("rsp transaction changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_FOUND |-> rsp_ipv4_address == '0)
      else $error("address nonzero without a found record");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // one byte at a time never stalls input while the result side drains
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready)
      else $error("input stalled while result drains");

endmodule

bind dns_response_address_extractor_top dra_checker u_dra_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_ipv4_address (rsp_ipv4_address)
);
